@@ design/gps_pkg.sv @@
package gps_pkg;

  // register map of the configuration port
  typedef enum logic [2:0] {
    CFG_PITCH_L = 3'd0,
    CFG_PITCH_R = 3'd1,
    CFG_DELAY_L = 3'd2,
    CFG_DELAY_R = 3'd3,
    CFG_FB_GAIN = 3'd4,
    CFG_WET     = 3'd5,
    CFG_BYPASS  = 3'd6
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned RATIO_W    = 18;
  localparam int unsigned DELAY_W    = 21;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned WET_W      = 17;
  localparam int unsigned WIN_W      = 17;
  localparam int unsigned WIN_POINTS = 256;
  localparam logic [WET_W-1:0] UNITY = 17'h10000;

  typedef logic [WIN_W-1:0] win_tab_t [0:WIN_POINTS];

  // Hann window h[k] = (1 - cos(2 pi k / 256)) / 2 in Q1.16, cosine from the
  // integer recurrence in Q30
  function automatic win_tab_t build_win();
    win_tab_t tab;
    longint   ys [0:WIN_POINTS];
    longint   prev;
    longint   cur;
    longint   nxt;
    longint   y;
    prev  = 64'sd1073741824;
    cur   = 64'sd1073418433;
    ys[0] = prev;
    ys[1] = cur;
    for (int k = 1; k < WIN_POINTS; k++) begin
      nxt = ((2 * 64'sd1073418433 * cur + (64'sd1 <<< 29)) >>> 30) - prev;
      prev = cur;
      cur  = nxt;
      ys[k+1] = cur;
    end
    for (int k = 0; k <= WIN_POINTS; k++) begin
      y = ys[k];
      if (y > 64'sd1073741824) y = 64'sd1073741824;
      if (y < -64'sd1073741824) y = -64'sd1073741824;
      tab[k] = WIN_W'((64'sd1073741824 - y) >>> 15);
    end
    return tab;
  endfunction

  localparam win_tab_t WIN_TAB = build_win();

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

@@ design/gps_ram.sv @@
module gps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/granular_pitch_shifter_stereo_unit.sv @@
// Stereo granular pitch shifter with post-shift delay, feedback and dry/wet mix.
// Input channel: in_valid_i / in_stall_o carry one stereo sample word
// (in_left_i, in_right_i). Output channel: out_valid_o / out_stall_i carry one
// mixed word (out_left_o, out_right_o) per input word.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write only while the block is idle.
// Both channels run one after the other through one sequencer that reads and
// writes a grain memory and a delay memory (one write and one read port each, registered read).
// Per channel an item passes feedback, grain write, then per grain two grain reads,
// interpolation, window, product and add, then delay write, the delay reads and
// interpolation when that channel's delay is nonzero, and the mix; bypass words skip to done.
// One word is in work at a time; the next is accepted once the previous
// result sits in the output register, even if the receiver stalls it.
// A stalled result holds and the sequencer waits before loading the next one.
// After reset both memories are cleared, one entry of each per cycle, until the
// clear counter has run through every address; in_stall_o stays high during that pass.
module granular_pitch_shifter_stereo_unit #(
  parameter int unsigned GRAIN_LENGTH = 2048,
  parameter int unsigned GRAIN_COUNT  = 2,
  parameter int unsigned DELAY_DEPTH  = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gps_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [gps_pkg::SAMPLE_W-1:0] in_right_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gps_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [gps_pkg::SAMPLE_W-1:0] out_right_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned STORE_DEPTH = 4 * GRAIN_LENGTH;
  localparam int unsigned GW  = $clog2(STORE_DEPTH);
  localparam int unsigned DW  = $clog2(DELAY_DEPTH);
  localparam int unsigned PW  = GW + 16;
  localparam int unsigned CW  = $clog2(GRAIN_LENGTH);
  localparam int unsigned GIW = (GRAIN_COUNT > 1) ? $clog2(GRAIN_COUNT) : 1;
  localparam int unsigned CLW = ((GW > DW) ? GW : DW) + 1;
  localparam int unsigned RPW = DW + 10;
  localparam int unsigned TQ  = (1 << 24) / GRAIN_LENGTH;
  localparam int unsigned TR  = (1 << 24) % GRAIN_LENGTH;
  localparam logic [PW:0]  SPAN   = (PW+1)'(STORE_DEPTH) << 16;
  localparam logic [25:0]  DSPAN1 = 26'(DELAY_DEPTH * 256);
  localparam logic [25:0]  DSPAN2 = 26'(DELAY_DEPTH * 512);
  localparam logic [25:0]  DSPAN4 = 26'(DELAY_DEPTH * 1024);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FB, S_WRG, S_RD0, S_RD1, S_INT, S_WIN, S_PROD, S_ADD,
    S_WRD, S_DR0, S_DR1, S_DI, S_DF, S_MIX0, S_MIX1, S_MIX2, S_DONE
  } state_e;

  function automatic logic [CW-1:0] init_cnt(input int unsigned g);
    return CW'(g * GRAIN_LENGTH / GRAIN_COUNT);
  endfunction

  function automatic logic [23:0] init_t(input int unsigned g);
    return 24'((longint'(g * GRAIN_LENGTH / GRAIN_COUNT) << 24) / GRAIN_LENGTH);
  endfunction

  function automatic logic [CW-1:0] init_rem(input int unsigned g);
    return CW'((longint'(g * GRAIN_LENGTH / GRAIN_COUNT) << 24) % GRAIN_LENGTH);
  endfunction

  state_e state_q;
  logic [CLW-1:0] clr_q;
  logic           ch_q;
  logic [GIW-1:0] g_q;

  logic [gps_pkg::RATIO_W-1:0] ratio_q [2];
  logic [gps_pkg::DELAY_W-1:0] delay_q [2];
  logic [gps_pkg::GAIN_W-1:0]  gain_q;
  logic [gps_pkg::WET_W-1:0]   wet_q;
  logic                        bypass_q;
  logic [DW+7:0]               dred_q [2];

  logic [PW-1:0] pos_q [2][GRAIN_COUNT];
  logic [CW-1:0] cnt_q [2][GRAIN_COUNT];
  logic [23:0]   t_q   [2][GRAIN_COUNT];
  logic [CW-1:0] rem_q [2][GRAIN_COUNT];
  logic [GW-1:0] gwi_q;
  logic [DW-1:0] dwi_q;
  logic signed [gps_pkg::SAMPLE_W-1:0] fb_q [2];

  logic signed [gps_pkg::SAMPLE_W-1:0] x_q [2];
  logic signed [gps_pkg::SAMPLE_W-1:0] y_q [2];
  logic signed [gps_pkg::SAMPLE_W-1:0] s0_q;
  logic signed [gps_pkg::SAMPLE_W-1:0] s_q;
  logic signed [gps_pkg::SAMPLE_W-1:0] dval_q;
  logic signed [17:0]                  w_q;
  logic signed [27:0]                  acc_q;
  logic signed [47:0]                  mul_q;
  logic signed [47:0]                  mul2_q;
  logic signed [47:0]                  wmul_q;
  logic                                out_valid_q;
  logic signed [gps_pkg::SAMPLE_W-1:0] out_l_q;
  logic signed [gps_pkg::SAMPLE_W-1:0] out_r_q;

  // ---------------- memories ----------------
  logic                                g_we;
  logic [GW:0]                         g_waddr;
  logic [GW:0]                         g_raddr;
  logic [gps_pkg::SAMPLE_W-1:0]        g_wdata;
  logic [gps_pkg::SAMPLE_W-1:0]        g_rdata;
  logic                                d_we;
  logic [DW:0]                         d_waddr;
  logic [DW:0]                         d_raddr;
  logic [gps_pkg::SAMPLE_W-1:0]        d_wdata;
  logic [gps_pkg::SAMPLE_W-1:0]        d_rdata;

  gps_ram #(.WIDTH(gps_pkg::SAMPLE_W), .DEPTH(2 << GW)) u_grain_ram (
    .clk_i  (clk_i),
    .we_i   (g_we),
    .waddr_i(g_waddr),
    .wdata_i(g_wdata),
    .raddr_i(g_raddr),
    .rdata_o(g_rdata)
  );

  gps_ram #(.WIDTH(gps_pkg::SAMPLE_W), .DEPTH(2 << DW)) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  // ---------------- address and datapath helpers ----------------
  logic [PW-1:0]  cur_pos;
  logic [GW-1:0]  i0;
  logic [GW-1:0]  i1;
  logic [23:0]    cur_t;
  logic [gps_pkg::WIN_W-1:0] win_a;
  logic [gps_pkg::WIN_W-1:0] win_b;
  logic [RPW-1:0] rp_sum;
  logic [RPW-1:0] rp;
  logic [DW-1:0]  j0;
  logic [DW-1:0]  j1;
  logic [gps_pkg::WET_W-1:0] wet_c;
  logic [gps_pkg::WET_W-1:0] dry_c;
  logic signed [gps_pkg::SAMPLE_W-1:0] g_in;
  logic signed [gps_pkg::SAMPLE_W-1:0] shifted;
  logic signed [47:0] mix_sum;
  logic [25:0]    dr0, dr1, dr2, dr3;
  logic [DW+7:0]  dred_d [2];

  always_comb begin
    cur_pos = pos_q[ch_q][g_q];
    i0      = cur_pos[PW-1:16];
    i1      = (32'(i0) + 32'd1 == STORE_DEPTH) ? '0 : i0 + GW'(1);
    cur_t   = t_q[ch_q][g_q];
    win_a   = gps_pkg::WIN_TAB[9'(cur_t[23:16])];
    win_b   = gps_pkg::WIN_TAB[9'(cur_t[23:16]) + 9'd1];
    rp_sum  = (RPW'(dwi_q) << 8) + RPW'(DSPAN1) - RPW'(dred_q[ch_q]);
    rp      = (rp_sum >= RPW'(DSPAN1)) ? rp_sum - RPW'(DSPAN1) : rp_sum;
    j0      = rp[DW+7:8];
    j1      = (32'(j0) + 32'd1 == DELAY_DEPTH) ? '0 : j0 + DW'(1);
    wet_c   = (wet_q > gps_pkg::UNITY) ? gps_pkg::UNITY : wet_q;
    dry_c   = gps_pkg::UNITY - wet_c;
    g_in    = gps_pkg::sat24(48'(x_q[ch_q]) + (mul_q >>> 16));
    shifted = gps_pkg::sat24(48'(acc_q));
    mix_sum = (mul_q + mul2_q) >>> 16;
  end

  // delay modulo the delay span, refreshed every cycle from the registers
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      dr0 = 26'(delay_q[c]);
      dr1 = (dr0 >= DSPAN4) ? dr0 - DSPAN4 : dr0;
      dr2 = (dr1 >= DSPAN2) ? dr1 - DSPAN2 : dr1;
      dr3 = (dr2 >= DSPAN1) ? dr2 - DSPAN1 : dr2;
      dred_d[c] = dr3[DW+7:0];
    end
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = {ch_q, gwi_q};
    g_wdata = g_in;
    g_raddr = {ch_q, (state_q == S_RD1) ? i1 : i0};
    d_we    = 1'b0;
    d_waddr = {ch_q, dwi_q};
    d_wdata = shifted;
    d_raddr = {ch_q, (state_q == S_DR1) ? j1 : j0};
    if (state_q == S_CLEAR) begin
      g_we    = 1'b1;
      g_waddr = clr_q[GW:0];
      g_wdata = '0;
      d_we    = 1'b1;
      d_waddr = clr_q[DW:0];
      d_wdata = '0;
    end else if (state_q == S_WRG) begin
      g_we = 1'b1;
    end else if (state_q == S_WRD) begin
      d_we = 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  logic [PW:0]   npos;
  logic [PW:0]   npos_w;
  logic [CW:0]   rem_sum;
  logic [CW:0]   cnt_inc;

  always_comb begin
    npos    = {1'b0, cur_pos} + (PW+1)'(ratio_q[ch_q]);
    npos_w  = (npos >= SPAN) ? npos - SPAN : npos;
    rem_sum = {1'b0, rem_q[ch_q][g_q]} + (CW+1)'(TR);
    cnt_inc = {1'b0, cnt_q[ch_q][g_q]} + (CW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ch_q        <= 1'b0;
      g_q         <= '0;
      ratio_q[0]  <= gps_pkg::RATIO_W'(65536);
      ratio_q[1]  <= gps_pkg::RATIO_W'(65536);
      delay_q[0]  <= '0;
      delay_q[1]  <= '0;
      dred_q[0]   <= '0;
      dred_q[1]   <= '0;
      gain_q      <= '0;
      wet_q       <= '0;
      bypass_q    <= 1'b0;
      gwi_q       <= '0;
      dwi_q       <= '0;
      fb_q[0]     <= '0;
      fb_q[1]     <= '0;
      out_valid_q <= 1'b0;
      out_l_q     <= '0;
      out_r_q     <= '0;
      for (int c = 0; c < 2; c++) begin
        for (int g = 0; g < GRAIN_COUNT; g++) begin
          pos_q[c][g] <= PW'(init_cnt(g)) << 16;
          cnt_q[c][g] <= init_cnt(g);
          t_q[c][g]   <= init_t(g);
          rem_q[c][g] <= init_rem(g);
        end
      end
    end else begin
      dred_q[0] <= dred_d[0];
      dred_q[1] <= dred_d[1];
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gps_pkg::CFG_PITCH_L: ratio_q[0] <= cfg_data_i[gps_pkg::RATIO_W-1:0];
          gps_pkg::CFG_PITCH_R: ratio_q[1] <= cfg_data_i[gps_pkg::RATIO_W-1:0];
          gps_pkg::CFG_DELAY_L: delay_q[0] <= cfg_data_i;
          gps_pkg::CFG_DELAY_R: delay_q[1] <= cfg_data_i;
          gps_pkg::CFG_FB_GAIN: gain_q     <= cfg_data_i[gps_pkg::GAIN_W-1:0];
          gps_pkg::CFG_WET:     wet_q      <= cfg_data_i[gps_pkg::WET_W-1:0];
          gps_pkg::CFG_BYPASS:  bypass_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CLW'(1);
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            ch_q    <= 1'b0;
            state_q <= bypass_q ? S_DONE : S_FB;
          end
        end
        S_FB:   state_q <= S_WRG;
        S_WRG: begin
          g_q     <= '0;
          state_q <= S_RD0;
        end
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_INT;
        S_INT:  state_q <= S_WIN;
        S_WIN:  state_q <= S_PROD;
        S_PROD: state_q <= S_ADD;
        S_ADD: begin
          if (cnt_inc >= (CW+1)'(GRAIN_LENGTH)) begin
            cnt_q[ch_q][g_q] <= '0;
            t_q[ch_q][g_q]   <= '0;
            rem_q[ch_q][g_q] <= '0;
            pos_q[ch_q][g_q] <= PW'(gwi_q) << 16;
          end else begin
            cnt_q[ch_q][g_q] <= cnt_inc[CW-1:0];
            pos_q[ch_q][g_q] <= npos_w[PW-1:0];
            if (rem_sum >= (CW+1)'(GRAIN_LENGTH)) begin
              rem_q[ch_q][g_q] <= CW'(rem_sum - (CW+1)'(GRAIN_LENGTH));
              t_q[ch_q][g_q]   <= t_q[ch_q][g_q] + 24'(TQ) + 24'd1;
            end else begin
              rem_q[ch_q][g_q] <= rem_sum[CW-1:0];
              t_q[ch_q][g_q]   <= t_q[ch_q][g_q] + 24'(TQ);
            end
          end
          if (g_q == GIW'(GRAIN_COUNT - 1)) begin
            state_q <= S_WRD;
          end else begin
            g_q     <= g_q + GIW'(1);
            state_q <= S_RD0;
          end
        end
        S_WRD:  state_q <= (delay_q[ch_q] == '0) ? S_MIX0 : S_DR0;
        S_DR0:  state_q <= S_DR1;
        S_DR1:  state_q <= S_DI;
        S_DI:   state_q <= S_DF;
        S_DF:   state_q <= S_MIX0;
        S_MIX0: begin
          fb_q[ch_q] <= dval_q;
          state_q    <= S_MIX1;
        end
        S_MIX1: state_q <= S_MIX2;
        S_MIX2: begin
          if (ch_q) begin
            gwi_q   <= (32'(gwi_q) + 32'd1 == STORE_DEPTH) ? '0 : gwi_q + GW'(1);
            dwi_q   <= (32'(dwi_q) + 32'd1 == DELAY_DEPTH) ? '0 : dwi_q + DW'(1);
            state_q <= S_DONE;
          end else begin
            ch_q    <= 1'b1;
            state_q <= S_FB;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_l_q     <= y_q[0];
            out_r_q     <= y_q[1];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        x_q[0] <= in_left_i;
        x_q[1] <= in_right_i;
        y_q[0] <= in_left_i;
        y_q[1] <= in_right_i;
      end
      S_FB: begin
        mul_q <= 48'(fb_q[ch_q]) * 48'($signed({1'b0, gain_q}));
        acc_q <= '0;
      end
      S_RD1:  s0_q <= g_rdata;
      S_INT: begin
        mul_q  <= (48'($signed(g_rdata)) - 48'(s0_q)) *
                  48'($signed({1'b0, cur_pos[15:0]}));
        wmul_q <= (48'($signed({1'b0, win_b})) - 48'($signed({1'b0, win_a}))) *
                  48'($signed({1'b0, cur_t[15:0]}));
      end
      S_WIN: begin
        s_q <= 24'(48'(s0_q) + (mul_q >>> 16));
        w_q <= 18'(48'($signed({1'b0, win_a})) + (wmul_q >>> 16));
      end
      S_PROD: mul_q <= 48'(s_q) * 48'(w_q);
      S_ADD:  acc_q <= acc_q + 28'(mul_q >>> 16);
      S_WRD:  dval_q <= shifted;
      S_DR1:  s0_q <= d_rdata;
      S_DI: begin
        mul_q <= (48'($signed(d_rdata)) - 48'(s0_q)) * 48'($signed({1'b0, rp[7:0]}));
      end
      S_DF:   dval_q <= 24'(48'(s0_q) + (mul_q >>> 8));
      S_MIX0: mul_q  <= 48'(x_q[ch_q]) * 48'($signed({1'b0, dry_c}));
      S_MIX1: mul2_q <= 48'(dval_q) * 48'($signed({1'b0, wet_c}));
      S_MIX2: y_q[ch_q] <= gps_pkg::sat24(mix_sum);
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign cfg_ready_o = 1'b1;

  // ---------------- assertions ----------------
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o)
    else $error("input accepted during memory clear");

  a_wr_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(gwi_q) < STORE_DEPTH && 32'(dwi_q) < DELAY_DEPTH)
    else $error("write index out of range");

  a_grain_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[ch_q][g_q]) < GRAIN_LENGTH && {1'b0, pos_q[ch_q][g_q]} < SPAN)
    else $error("grain count or position out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("output word loaded outside the done state");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_FB || state_q == S_DONE)
    else $error("accepted word not started");

endmodule
